// File: hw/rtl/obco_pkg.sv
//------------------------------------------------------------------------------
// obco_pkg
// Shared types, constants and the quarter-wave sine table for the box overlap unit.
//------------------------------------------------------------------------------
package obco_pkg;

	localparam int MAX_ROADS_DEF    = 1024;
	localparam int SINE_ENTRIES_DEF = 256;
	localparam int CLEAR_RESET      = 2000;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_AXES,
		ST_PROJ,
		ST_SUM,
		ST_DONE,
		ST_FETCH
	} state_t;

	// one road entry as stored
	typedef struct packed {
		logic signed [20:0] x;
		logic signed [20:0] y;
		logic [15:0]        heading;
		logic [15:0]        half_length;
		logic [15:0]        half_width;
	} road_t;

	typedef struct packed {
		logic intersects;
		logic [10:0] road_count;
		logic table_full;
	} result_t;

	// Horner steps of the sine polynomial, truncation toward zero
	function automatic longint q30_mul(input longint a, input longint b);
		longint p;
		p = a * b;
		if (p < 0) return -((-p) >>> 30);
		return p >>> 30;
	endfunction

	// p is the table phase k/SINE_ENTRIES in Q30
	function automatic logic [14:0] sine_entry(input longint p);
		longint u, acc, s;
		u = q30_mul(p, p);
		acc = 64'sd172273;
		acc = -64'sd5026995 + q30_mul(acc, u);
		acc = 64'sd85569306 + q30_mul(acc, u);
		acc = -64'sd693598668 + q30_mul(acc, u);
		acc = 64'sd1686629713 + q30_mul(acc, u);
		s = q30_mul(acc, p);
		if (s < 0) s = 0;
		s = (s + 16384) >>> 15;
		if (s > 32767) s = 32767;
		return s[14:0];
	endfunction

endpackage

// File: hw/rtl/oriented_box_corridor_overlap_unit.sv
//------------------------------------------------------------------------------
// oriented_box_corridor_overlap_unit
// Road rectangle table with a building footprint overlap query.
//------------------------------------------------------------------------------
// Usage:
//  s_axis carries one command per transaction: clear, append a road, or query
//  a footprint. m_axis returns one result per command: intersects, the road
//  count after the command and table_full for a dropped append.
//  cfg_tvalid/cfg_tready write road_clearance (reset 2000); the user must write
//  it only while idle, as the block does not enforce this.
// Sequencing:
//  Clear and append put their result out in the cycle after acceptance. A
//  query reads the road memory one entry at a time; each pair goes through
//  memory read, sine lookup, test start, four axes of three steps and done.
//  A query stops at a hit. The road memory read port and the single test
//  unit handle the roads one at a time.
// Reset:
//  The count clears at once, clearance goes to 2000; memory is not cleared.
// Stalls:
//  The result waits in an output register; a new command is taken only once
//  the previous result has been delivered.
//------------------------------------------------------------------------------
module oriented_box_corridor_overlap_unit #(
	parameter int MAX_ROADS    = obco_pkg::MAX_ROADS_DEF,
	parameter int SINE_ENTRIES = obco_pkg::SINE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: opcode[1:0] pos_x[22:2] pos_y[43:23] heading[59:44]
	//        size_long[75:60] size_cross[91:76] overhang[101:92]
	input  logic [103:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: intersects[0] road_count[11:1] table_full[12]
	output logic [15:0] m_tdata,
	input  logic        cfg_tvalid,
	output logic        cfg_tready,
	input  logic [15:0] cfg_tdata
);
	localparam int AW = (MAX_ROADS > 1) ? $clog2(MAX_ROADS) : 1;
	localparam int CW = $clog2(MAX_ROADS + 1);

	obco_pkg::state_t st_q, st_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [15:0]   clear_q;
	logic          out_v_q;
	obco_pkg::result_t res_q;

	// held query
	logic signed [20:0] qx_q, qy_q;
	logic [17:0] ql_q, qw_q;

	obco_pkg::road_t rd, wr;
	logic sat_start, sat_done, sat_ovl;
	logic signed [16:0] sa_s, sa_c, sb_s, sb_c;
	logic signed [16:0] a_fx_q, a_fy_q;

	assign cfg_tready = 1'b1;
	assign s_tready = (st_q == obco_pkg::ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = {3'b0, res_q.table_full, res_q.road_count, res_q.intersects};

	logic acc;
	obco_pkg::op_t op;
	assign acc = s_tvalid && s_tready;
	assign op = obco_pkg::op_t'(s_tdata[1:0]);

	assign wr.x = s_tdata[22:2];
	assign wr.y = s_tdata[43:23];
	assign wr.heading = s_tdata[59:44];
	assign wr.half_length = s_tdata[75:60];
	assign wr.half_width = s_tdata[91:76];

	obco_store #(.MAX_ROADS(MAX_ROADS)) u_store (
		.clk(clk),
		.wr_en(acc && op == obco_pkg::OP_APPEND && count_q < CW'(MAX_ROADS)),
		.wr_addr(AW'(count_q)),
		.wr_data(wr),
		.rd_addr(AW'(idx_q)),
		.rd_data(rd)
	);

	// query heading lookup, sampled once at acceptance
	obco_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_sine_a (
		.clk(clk), .angle(s_tdata[59:44]), .sin_val(sa_s), .cos_val(sa_c)
	);
	obco_sine #(.SINE_ENTRIES(SINE_ENTRIES)) u_sine_b (
		.clk(clk), .angle(rd.heading), .sin_val(sb_s), .cos_val(sb_c)
	);

	logic signed [21:0] dx, dy;
	assign dx = 22'(rd.x) - 22'(qx_q);
	assign dy = 22'(rd.y) - 22'(qy_q);

	obco_sat u_sat (
		.clk(clk), .start(sat_start), .dx(dx), .dy(dy),
		.va_fx(a_fx_q), .va_fy(a_fy_q), .vb_fx(sb_c), .vb_fy(sb_s),
		.al(ql_q), .aw(qw_q),
		.bl({1'b0, rd.half_length, 1'b0}),
		.bw(18'({1'b0, rd.half_width} + {1'b0, clear_q}) << 1),
		.done(sat_done), .overlap(sat_ovl)
	);

	// next state
	always_comb begin
		st_d = st_q;
		sat_start = 1'b0;
		unique case (st_q)
			obco_pkg::ST_IDLE: begin
				if (acc && op == obco_pkg::OP_QUERY) st_d = obco_pkg::ST_AXES;
			end
			obco_pkg::ST_AXES: st_d = obco_pkg::ST_RUN;
			// wait out the memory read of the next road
			obco_pkg::ST_FETCH: st_d = obco_pkg::ST_RUN;
			obco_pkg::ST_RUN: begin
				// memory read for idx_q lands; sine for it next cycle
				if (idx_q >= count_q) st_d = obco_pkg::ST_DONE;
				else st_d = obco_pkg::ST_PROJ;
			end
			obco_pkg::ST_PROJ: begin
				sat_start = 1'b1;
				st_d = obco_pkg::ST_SUM;
			end
			obco_pkg::ST_SUM: begin
				if (sat_done) st_d = sat_ovl ? obco_pkg::ST_DONE : obco_pkg::ST_FETCH;
			end
			default: st_d = obco_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= obco_pkg::ST_IDLE;
			count_q <= '0;
			clear_q <= 16'(obco_pkg::CLEAR_RESET);
			out_v_q <= 1'b0;
			idx_q <= '0;
			res_q <= '0;
			a_fx_q <= '0;
			a_fy_q <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_tvalid) clear_q <= cfg_tdata;
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			if (acc) begin
				idx_q <= '0;
				res_q.intersects <= 1'b0;
				res_q.table_full <= 1'b0;
				unique case (op)
					obco_pkg::OP_CLEAR: begin
						count_q <= '0;
						res_q.road_count <= '0;
						out_v_q <= 1'b1;
					end
					obco_pkg::OP_APPEND: begin
						if (count_q < CW'(MAX_ROADS)) begin
							count_q <= count_q + 1'b1;
							res_q.road_count <= 11'(count_q + 1'b1);
						end else begin
							res_q.table_full <= 1'b1;
							res_q.road_count <= 11'(count_q);
						end
						out_v_q <= 1'b1;
					end
					obco_pkg::OP_QUERY: res_q.road_count <= 11'(count_q);
					default: begin
						res_q.road_count <= 11'(count_q);
						out_v_q <= 1'b1;
					end
				endcase
			end
			if (st_q == obco_pkg::ST_AXES) begin
				a_fx_q <= sa_c;
				a_fy_q <= sa_s;
			end
			// advance to next road after a miss
			if (st_q == obco_pkg::ST_SUM && sat_done) begin
				if (sat_ovl) res_q.intersects <= 1'b1;
				else idx_q <= idx_q + 1'b1;
			end
			if (st_q == obco_pkg::ST_DONE) out_v_q <= 1'b1;
		end
	end

	// hold query fields
	always_ff @(posedge clk) begin
		if (acc) begin
			qx_q <= s_tdata[22:2];
			qy_q <= s_tdata[43:23];
			ql_q <= 18'(s_tdata[75:60]) + 18'({s_tdata[101:92], 1'b0});
			qw_q <= 18'(s_tdata[91:76]) + 18'({s_tdata[101:92], 1'b0});
		end
	end
endmodule

// File: hw/rtl/obco_sine.sv
//------------------------------------------------------------------------------
// obco_sine
// Registered sine and cosine lookup of a binary angle, Q1.15 result.
//------------------------------------------------------------------------------
module obco_sine #(
	parameter int SINE_ENTRIES = obco_pkg::SINE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic [15:0]        angle,
	output logic signed [16:0] sin_val,
	output logic signed [16:0] cos_val
);
	localparam int IW = $clog2(SINE_ENTRIES + 1);

	logic [14:0] rom [SINE_ENTRIES + 1];

	for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
		localparam longint PHASE = (longint'(k) <<< 30) / longint'(SINE_ENTRIES);
		localparam logic [14:0] ENTRY = obco_pkg::sine_entry(PHASE);
		assign rom[k] = ENTRY;
	end

	function automatic logic signed [16:0] look(input logic [15:0] a,
			input logic [14:0] tbl [SINE_ENTRIES + 1]);
		logic [14:0] f;
		logic [31:0] prod;
		logic [IW-1:0] idx;
		logic signed [16:0] v;
		f = {1'b0, a[13:0]};
		if (a[14]) f = 15'd16384 - f;
		prod = 32'(f) * 32'(SINE_ENTRIES);
		idx = IW'(prod >> 14);
		v = 17'(tbl[idx]);
		return a[15] ? -v : v;
	endfunction

	always_ff @(posedge clk) begin
		sin_val <= look(angle, rom);
		cos_val <= look(angle + 16'd16384, rom);
	end
endmodule

// File: hw/rtl/obco_store.sv
//------------------------------------------------------------------------------
// obco_store
// Road table memory: one write port, one registered read port.
//------------------------------------------------------------------------------
module obco_store #(
	parameter int MAX_ROADS = obco_pkg::MAX_ROADS_DEF,
	localparam int AW = (MAX_ROADS > 1) ? $clog2(MAX_ROADS) : 1
) (
	input  logic           clk,
	input  logic           wr_en,
	input  logic [AW-1:0]  wr_addr,
	input  obco_pkg::road_t wr_data,
	input  logic [AW-1:0]  rd_addr,
	output obco_pkg::road_t rd_data
);
	obco_pkg::road_t mem [MAX_ROADS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// File: hw/rtl/obco_sat.sv
//------------------------------------------------------------------------------
// obco_sat
// Four-axis separating-axis test of one pair, sequenced one axis at a time.
//------------------------------------------------------------------------------
module obco_sat (
	input  logic               clk,
	input  logic               start,
	input  logic signed [21:0] dx,
	input  logic signed [21:0] dy,
	input  logic signed [16:0] va_fx,
	input  logic signed [16:0] va_fy,
	input  logic signed [16:0] vb_fx,
	input  logic signed [16:0] vb_fy,
	input  logic [17:0]        al,
	input  logic [17:0]        aw,
	input  logic [17:0]        bl,
	input  logic [17:0]        bw,
	output logic               done,
	output logic               overlap
);
	// axis i: 0 A fwd, 1 A right, 2 B fwd, 3 B right
	logic [1:0]  ax_q;
	logic [2:0]  ph_q;
	logic        busy_q;
	logic        sep_q;
	logic signed [16:0] vx, vy;
	logic signed [39:0] px_q, py_q;
	logic signed [34:0] c0_q, c1_q, c2_q, c3_q;
	logic [52:0] ra0_q, ra1_q, rb0_q, rb1_q;
	logic [57:0] proj_mag;
	logic [54:0] rsum;

	always_comb begin
		unique case (ax_q)
			2'd0: begin vx = va_fx;  vy = va_fy; end
			2'd1: begin vx = -va_fy; vy = va_fx; end
			2'd2: begin vx = vb_fx;  vy = vb_fy; end
			default: begin vx = -vb_fy; vy = vb_fx; end
		endcase
	end

	function automatic logic [33:0] abs35(input logic signed [34:0] v);
		return v[34] ? 34'(-v) : 34'(v);
	endfunction

	always_comb begin
		logic signed [40:0] s;
		s = 41'(px_q) + 41'(py_q);
		proj_mag = {(s[40] ? 41'(-s) : s)} << 16;
		rsum = 55'(ra0_q) + 55'(ra1_q) + 55'(rb0_q) + 55'(rb1_q);
	end

	always_ff @(posedge clk) begin
		done <= 1'b0;
		if (start) begin
			busy_q <= 1'b1;
			ax_q <= '0;
			ph_q <= '0;
			sep_q <= 1'b0;
		end else if (busy_q) begin
			unique case (ph_q)
				3'd0: begin
					px_q <= 40'(dx * vx);
					py_q <= 40'(dy * vy);
					c0_q <= 35'(va_fx * vx) + 35'(va_fy * vy);
					c1_q <= 35'(-va_fy * vx) + 35'(va_fx * vy);
					c2_q <= 35'(vb_fx * vx) + 35'(vb_fy * vy);
					c3_q <= 35'(-vb_fy * vx) + 35'(vb_fx * vy);
					ph_q <= 3'd1;
				end
				3'd1: begin
					ra0_q <= 53'(al) * 53'(abs35(c0_q));
					ra1_q <= 53'(aw) * 53'(abs35(c1_q));
					rb0_q <= 53'(bl) * 53'(abs35(c2_q));
					rb1_q <= 53'(bw) * 53'(abs35(c3_q));
					ph_q <= 3'd2;
				end
				default: begin
					if (58'(proj_mag) > 58'(rsum)) sep_q <= 1'b1;
					ph_q <= 3'd0;
					if (ax_q == 2'd3) begin
						busy_q <= 1'b0;
						done <= 1'b1;
					end
					ax_q <= ax_q + 2'd1;
				end
			endcase
		end
	end

	assign overlap = !sep_q;
endmodule

// File: bench/obco_checker.sv
//------------------------------------------------------------------------------
// obco_checker
// Watches the command, result and clearance channels of the overlap unit,
// predicts each result from its own copy of the road table and compares.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module obco_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [15:0]  m_tdata,
	input  logic         cfg_tvalid,
	input  logic         cfg_tready,
	input  logic [15:0]  cfg_tdata,
	output int           pending,
	output int           fail_count
);
	localparam int TABLE_DEPTH = obco_pkg::MAX_ROADS_DEF;
	localparam int ROM_STEPS   = obco_pkg::SINE_ENTRIES_DEF;
	localparam longint ONE_Q30 = 64'sd1073741824;

	longint    sine_rom [0:ROM_STEPS];
	obco_pkg::road_t   roads [TABLE_DEPTH];
	int        stored;
	logic [15:0] clearance;
	obco_pkg::result_t awaited [$];

	// truncating division toward zero matches the fixed-point Horner steps
	function automatic longint qmul(input longint a, input longint b);
		return (a * b) / ONE_Q30;
	endfunction

	initial begin
		longint p, u, acc, s;
		for (int k = 0; k <= ROM_STEPS; k++) begin
			p = (longint'(k) << 30) / ROM_STEPS;
			u = qmul(p, p);
			acc = 172273;
			acc = -5026995 + qmul(acc, u);
			acc = 85569306 + qmul(acc, u);
			acc = -693598668 + qmul(acc, u);
			acc = 1686629713 + qmul(acc, u);
			s = qmul(acc, p);
			if (s < 0) s = 0;
			s = (s + 16384) / 32768;
			if (s > 32767) s = 32767;
			sine_rom[k] = s;
		end
	end

	function automatic longint sine_of(input logic [15:0] ang);
		longint f, idx;
		f = ang[13:0];
		if (ang[14]) f = 16384 - f;
		idx = (f * ROM_STEPS) >> 14;
		if (idx > ROM_STEPS) idx = ROM_STEPS;
		return ang[15] ? -sine_rom[idx] : sine_rom[idx];
	endfunction

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// separating-axis test; lengths in half centimetres
	function automatic bit boxes_touch(input longint ax, input longint ay,
			input logic [15:0] ah, input longint al, input longint aw,
			input longint bx, input longint by, input logic [15:0] bh,
			input longint bl, input longint bw);
		longint vx [4];
		longint vy [4];
		longint dx, dy, span, ra, rb;
		vx[0] = sine_of(ah + 16'd16384); vy[0] = sine_of(ah);
		vx[1] = -vy[0];                  vy[1] = vx[0];
		vx[2] = sine_of(bh + 16'd16384); vy[2] = sine_of(bh);
		vx[3] = -vy[2];                  vy[3] = vx[2];
		dx = bx - ax;
		dy = by - ay;
		for (int i = 0; i < 4; i++) begin
			span = mag(dx * vx[i] + dy * vy[i]) * 65536;
			ra = al * mag(vx[0] * vx[i] + vy[0] * vy[i]) + aw * mag(vx[1] * vx[i] + vy[1] * vy[i]);
			rb = bl * mag(vx[2] * vx[i] + vy[2] * vy[i]) + bw * mag(vx[3] * vx[i] + vy[3] * vy[i]);
			if (span > ra + rb) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic obco_pkg::result_t predict_command(input logic [103:0] d);
		obco_pkg::result_t r;
		obco_pkg::op_t op;
		obco_pkg::road_t q;
		logic [9:0] ov;
		longint ql, qw;
		op = obco_pkg::op_t'(d[1:0]);
		q = '{x: d[22:2], y: d[43:23], heading: d[59:44], half_length: d[75:60],
			half_width: d[91:76]};
		ov = d[101:92];
		r = '0;
		case (op)
			obco_pkg::OP_CLEAR: stored = 0;
			obco_pkg::OP_APPEND: begin
				if (stored < TABLE_DEPTH) begin
					roads[stored] = q;
					stored++;
				end else r.table_full = 1'b1;
			end
			obco_pkg::OP_QUERY: begin
				ql = longint'(q.half_length) + 2 * longint'(ov);
				qw = longint'(q.half_width) + 2 * longint'(ov);
				for (int i = 0; i < stored && !r.intersects; i++)
					r.intersects = boxes_touch(q.x, q.y, q.heading, ql, qw,
						roads[i].x, roads[i].y, roads[i].heading,
						2 * longint'(roads[i].half_length),
						2 * (longint'(roads[i].half_width) + longint'(clearance)));
			end
			default: ;
		endcase
		r.road_count = stored[10:0];
		return r;
	endfunction

	assign pending = awaited.size();

	always @(posedge clk or negedge arst_n) begin
		obco_pkg::result_t want, got;
		if (!arst_n) begin
			stored = 0;
			clearance = 16'(obco_pkg::CLEAR_RESET);
			awaited.delete();
			fail_count = 0;
		end else begin
			if (cfg_tvalid && cfg_tready) clearance = cfg_tdata;
			if (s_tvalid && s_tready) awaited.push_back(predict_command(s_tdata));
			if (m_tvalid && m_tready) begin
				got = '{intersects: m_tdata[0], road_count: m_tdata[11:1], table_full: m_tdata[12]};
				if (awaited.size() == 0) begin
					$error("unexpected result transaction %h", m_tdata);
					fail_count++;
				end else begin
					want = awaited.pop_front();
					if (got.intersects !== want.intersects) begin
						$error("intersects: expected %0d got %0d", want.intersects, got.intersects);
						fail_count++;
					end
					if (got.road_count !== want.road_count) begin
						$error("road_count: expected %0d got %0d", want.road_count, got.road_count);
						fail_count++;
					end
					if (got.table_full !== want.table_full) begin
						$error("table_full: expected %0d got %0d", want.table_full, got.table_full);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

// File: bench/oriented_box_corridor_overlap_unit_tb.sv
//------------------------------------------------------------------------------
// oriented_box_corridor_overlap_unit_tb
// Drives clear, append, query and unused commands into the overlap unit under
// several clearance settings, with random gaps and back-pressure; the checker
// predicts and compares every result.
//------------------------------------------------------------------------------
`timescale 1ns / 100ps

module oriented_box_corridor_overlap_unit_tb;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [15:0]  m_tdata;
	logic         cfg_tvalid;
	logic         cfg_tready;
	logic [15:0]  cfg_tdata;
	int           pending;
	int           fail_count;

	// stimulus-side shadow of the table size, used only to steer commands
	int  roads_loaded;
	// when set, both sides run without gaps for a stretch
	bit  burst_mode;
	int  cycle_no;

	oriented_box_corridor_overlap_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata)
	);

	obco_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_tvalid(cfg_tvalid), .cfg_tready(cfg_tready), .cfg_tdata(cfg_tdata),
		.pending(pending), .fail_count(fail_count)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Hard stop: far above the slowest run.
	initial begin
		#30_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Gap lengths: mostly none or short, a few long; none at all in burst mode.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (burst_mode || r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver: random stalls, plus one long hold-off while the sender keeps
	// offering commands, so the unit backs up and drops s_tready.
	always @(posedge clk or negedge arst_n) begin
		int stall_left;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			cycle_no = 0;
		end else begin
			cycle_no++;
			if (cycle_no == 1500) stall_left = 400;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				m_tready <= (stall_left == 0);
			end
		end
	end

	// Toggle gap-free stretches so phases with no idling occur too.
	always @(posedge clk) begin
		if (cycle_no % 3000 == 0) burst_mode <= ($urandom_range(0, 3) == 0);
	end

	function automatic logic [103:0] pack_cmd(input obco_pkg::op_t op, input logic [20:0] x,
			input logic [20:0] y, input logic [15:0] hd, input logic [15:0] sl,
			input logic [15:0] sc, input logic [9:0] ov);
		return {2'b00, ov, sc, sl, hd, y, x, op};
	endfunction

	// Offer one command after a random gap; hold it until the transaction.
	task automatic send_cmd(input logic [103:0] cmd);
		int g;
		g = pick_gap();
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= cmd;
		do @(posedge clk); while (!s_tready);
		case (obco_pkg::op_t'(cmd[1:0]))
			obco_pkg::OP_CLEAR:  roads_loaded = 0;
			obco_pkg::OP_APPEND: if (roads_loaded < obco_pkg::MAX_ROADS_DEF) roads_loaded++;
			default: ;
		endcase
	endtask

	// Write the clearance only once every result is back, so the unit is idle.
	task automatic write_clearance(input logic [15:0] val);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_tvalid <= 1'b1;
		cfg_tdata  <= val;
		do @(posedge clk); while (!cfg_tready);
		cfg_tvalid <= 1'b0;
	endtask

	// Coordinates: mostly a crowded neighborhood so overlaps happen, sometimes anywhere.
	function automatic logic [20:0] near_coord();
		if ($urandom_range(0, 9) == 0) return 21'($urandom);
		return 21'($signed($urandom_range(0, 12000)) - 6000);
	endfunction

	function automatic logic [15:0] some_size();
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 3000));
	endfunction

	// Random command: appends and queries dominate; clear keeps the table short.
	function automatic logic [103:0] random_cmd();
		int r;
		obco_pkg::op_t op;
		r = $urandom_range(0, 99);
		if (r < 4 || (roads_loaded >= 16 && r < 30)) op = obco_pkg::OP_CLEAR;
		else if (r < 45) op = obco_pkg::OP_APPEND;
		else if (r < 94) op = obco_pkg::OP_QUERY;
		else op = obco_pkg::OP_NONE;
		return pack_cmd(op, near_coord(), near_coord(), 16'($urandom), some_size(),
			some_size(), 10'($urandom));
	endfunction

	initial begin
		logic [15:0] settings [4];
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		cfg_tvalid = 1'b0;
		cfg_tdata  = '0;
		roads_loaded = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty query, unused opcode, extreme fields and headings.
		send_cmd(pack_cmd(obco_pkg::OP_QUERY, 21'd0, 21'd0, 16'd0, 16'd100, 16'd100, 10'd0));
		send_cmd(pack_cmd(obco_pkg::OP_NONE, 21'h1FFFFF, 21'h1FFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 10'h3FF));
		send_cmd(pack_cmd(obco_pkg::OP_APPEND, 21'd0, 21'd0, 16'd0, 16'd500, 16'd100, 10'h3FF));
		send_cmd(pack_cmd(obco_pkg::OP_QUERY, 21'd0, 21'd0, 16'd0, 16'd10, 16'd10, 10'd0));
		send_cmd(pack_cmd(obco_pkg::OP_QUERY, 21'd20000, 21'd20000, 16'd16384, 16'd0, 16'd0,
			10'd0));
		send_cmd(pack_cmd(obco_pkg::OP_APPEND, 21'h100000, 21'h0FFFFF, 16'd16384, 16'hFFFF,
			16'hFFFF, 10'd0));
		send_cmd(pack_cmd(obco_pkg::OP_APPEND, 21'h0FFFFF, 21'h100000, 16'd32768, 16'd0, 16'd0,
			10'd0));
		send_cmd(pack_cmd(obco_pkg::OP_APPEND, 21'd3000, 21'd0, 16'd49152, 16'd200, 16'd0,
			10'd0));
		send_cmd(pack_cmd(obco_pkg::OP_QUERY, 21'h100000, 21'h100000, 16'hFFFF, 16'd0, 16'd0,
			10'h3FF));
		send_cmd(pack_cmd(obco_pkg::OP_QUERY, 21'h0FFFFF, 21'h0FFFFF, 16'd8192, 16'hFFFF,
			16'hFFFF, 10'h3FF));
		send_cmd(pack_cmd(obco_pkg::OP_QUERY, 21'd5400, 21'd0, 16'd0, 16'd0, 16'd0, 10'd0));
		send_cmd(pack_cmd(obco_pkg::OP_QUERY, 21'd5401, 21'd0, 16'd16384, 16'd1, 16'd1, 10'd0));
		send_cmd(pack_cmd(obco_pkg::OP_NONE, 21'd0, 21'd0, 16'd0, 16'd0, 16'd0, 10'd0));
		send_cmd(pack_cmd(obco_pkg::OP_CLEAR, 21'h1FFFFF, 21'h1FFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 10'h3FF));
		send_cmd(pack_cmd(obco_pkg::OP_QUERY, 21'd0, 21'd0, 16'd0, 16'hFFFF, 16'hFFFF, 10'h3FF));
		send_cmd(pack_cmd(obco_pkg::OP_APPEND, 21'd0, 21'd0, 16'd12345, 16'd1000, 16'd1000,
			10'd0));
		send_cmd(pack_cmd(obco_pkg::OP_QUERY, 21'd0, 21'd0, 16'd54321, 16'd0, 16'd0, 10'd0));

		// Random phases across clearance extremes and random settings.
		settings = '{16'd0, 16'hFFFF, 16'($urandom), 16'd2000};
		foreach (settings[i]) begin
			write_clearance(settings[i]);
			repeat (140) send_cmd(random_cmd());
		end
		s_tvalid <= 1'b0;

		// Drain, then keep watching for any stray result.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule
